FILE: rtl/mp2d_pkg.sv
// Shared types, constants and helpers for the int8 2-D max pooling block.
package mp2d_pkg;

   // Default sizing handed to the top-level parameters
   localparam int MAX_WIDTH_DEF   = 256;
   localparam int MAX_HEIGHT_DEF  = 256;
   localparam int KERNEL_ROWS_DEF = 3;
   localparam int KERNEL_COLS_DEF = 3;

   // Field and register widths
   localparam int SAMPLE_W  = 8;
   localparam int IDX_W     = 8;
   localparam int DIM_W     = 9;
   localparam int STRIDE_W  = 4;
   localparam int PAD_W     = 3;
   localparam int CSR_IDX_W = 3;
   localparam int RSP_W     = SAMPLE_W + 2 * IDX_W;

   // Window edge positions: out index * stride + kernel, signed
   localparam int POS_W = 15;

   // Results per input beat
   localparam int RES_MAX = 64;
   localparam int N_W     = $clog2(RES_MAX + 1);

   localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

   // Register reset values
   localparam logic [DIM_W-1:0]    IN_HEIGHT_RST   = DIM_W'(8);
   localparam logic [DIM_W-1:0]    IN_WIDTH_RST    = DIM_W'(8);
   localparam logic [DIM_W-1:0]    OUT_HEIGHT_RST  = DIM_W'(4);
   localparam logic [DIM_W-1:0]    OUT_WIDTH_RST   = DIM_W'(4);
   localparam logic [STRIDE_W-1:0] STRIDE_ROWS_RST = STRIDE_W'(2);
   localparam logic [STRIDE_W-1:0] STRIDE_COLS_RST = STRIDE_W'(2);
   localparam logic [PAD_W-1:0]    PAD_TOP_RST     = '0;
   localparam logic [PAD_W-1:0]    PAD_LEFT_RST    = '0;

   typedef logic signed [POS_W-1:0] pos_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_IN_HEIGHT,
      REG_IN_WIDTH,
      REG_OUT_HEIGHT,
      REG_OUT_WIDTH,
      REG_STRIDE_ROWS,
      REG_STRIDE_COLS,
      REG_PAD_TOP,
      REG_PAD_LEFT
   } csr_reg_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_ROW_ADV,
      S_COL_ADV,
      S_ROW_CHK,
      S_COL_CHK,
      S_SCAN,
      S_OUT
   } ctrl_state_type;

   typedef enum logic [1:0] {
      U_IDLE,
      U_READ,
      U_WAIT,
      U_DONE
   } unit_state_type;

   typedef struct packed {
      logic busy;
      logic done;
   } unit_status_type;

   // Does a window whose last row (col) sits at x fire at position p?
   // Windows hanging off either edge are clamped onto the edge row (col).
   function automatic logic pos_match(pos_type x, pos_type p, pos_type p_last);
      return (x == p) ||
             ((p == pos_type'(0)) && (x < pos_type'(0))) ||
             ((p == p_last) && (x > p_last));
   endfunction

endpackage

FILE: rtl/mp2d_ram.sv
// Generic simple dual-port RAM, one write port, one registered read port.
module mp2d_ram #(
   parameter int WIDTH  = 8,
   parameter int DEPTH  = 16,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/mp2d_maxunit.sv
// Window scanner: walks one pooling window through the line store, one read a cycle,
// and keeps the running maximum in a single shared compare unit.
module mp2d_maxunit import mp2d_pkg::*; #(
   parameter int MAX_WIDTH   = MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT  = MAX_HEIGHT_DEF,
   parameter int KERNEL_ROWS = KERNEL_ROWS_DEF,
   localparam int ROW_W  = $clog2(MAX_HEIGHT),
   localparam int COL_W  = $clog2(MAX_WIDTH),
   localparam int ADDR_W = $clog2(KERNEL_ROWS * MAX_WIDTH)
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [ROW_W-1:0]           row_lo,
   input  logic [ROW_W-1:0]           row_hi,
   input  logic [COL_W-1:0]           col_lo,
   input  logic [COL_W-1:0]           col_hi,
   input  logic [ADDR_W-1:0]          base,
   output logic                       rd_en,
   output logic [ADDR_W-1:0]          rd_addr,
   input  logic [SAMPLE_W-1:0]        rd_data,
   output logic signed [SAMPLE_W-1:0] max_value,
   output unit_status_type            status
);

   localparam logic [ADDR_W-1:0] ROW_STEP  = ADDR_W'(MAX_WIDTH);
   localparam logic [ADDR_W-1:0] LAST_BASE = ADDR_W'((KERNEL_ROWS - 1) * MAX_WIDTH);

   unit_state_type              st_ff, st_in;
   logic [ROW_W-1:0]            ih_ff, ih_in;
   logic [COL_W-1:0]            iw_ff, iw_in;
   logic [ADDR_W-1:0]           base_ff, base_in;
   logic [ROW_W-1:0]            row_lo_ff, row_lo_in;
   logic [COL_W-1:0]            col_lo_ff, col_lo_in;
   logic [COL_W-1:0]            col_hi_ff, col_hi_in;
   logic                        pend_ff, pend_in;
   logic signed [SAMPLE_W-1:0]  max_ff, max_in;
   logic signed [SAMPLE_W-1:0]  rd_sample;
   logic                        last_col;
   logic                        last_row;

   assign rd_sample = $signed(rd_data);
   assign last_col  = (iw_ff == col_hi_ff);
   assign last_row  = (ih_ff == row_lo_ff);

   // Next state
   always_comb begin
      st_in = st_ff;
      unique case (st_ff)
         U_IDLE: begin
            if (start) st_in = U_READ;
         end
         U_READ: begin
            if (last_col && last_row) st_in = U_WAIT;
         end
         U_WAIT: st_in = U_DONE;
         U_DONE: st_in = U_IDLE;
         default: st_in = U_IDLE;
      endcase
   end

   // Datapath
   always_comb begin
      ih_in     = ih_ff;
      iw_in     = iw_ff;
      base_in   = base_ff;
      row_lo_in = row_lo_ff;
      col_lo_in = col_lo_ff;
      col_hi_in = col_hi_ff;
      max_in    = max_ff;
      pend_in   = (st_ff == U_READ);
      rd_en     = (st_ff == U_READ);
      rd_addr   = base_ff + ADDR_W'(iw_ff);

      // read data lands in the cycle after its address
      if (pend_ff && (rd_sample > max_ff)) begin
         max_in = rd_sample;
      end

      unique case (st_ff)
         U_IDLE: begin
            if (start) begin
               ih_in     = row_hi;
               iw_in     = col_lo;
               base_in   = base;
               row_lo_in = row_lo;
               col_lo_in = col_lo;
               col_hi_in = col_hi;
               max_in    = SAMPLE_MIN;
            end
         end
         U_READ: begin
            if (!last_col) begin
               iw_in = iw_ff + COL_W'(1);
            end else if (!last_row) begin
               // step up one row, line store slots wrap
               iw_in   = col_lo_ff;
               ih_in   = ih_ff - ROW_W'(1);
               base_in = (base_ff == '0) ? LAST_BASE : base_ff - ROW_STEP;
            end
         end
         U_WAIT, U_DONE: begin
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff   <= U_IDLE;
         pend_ff <= 1'b0;
      end else begin
         st_ff   <= st_in;
         pend_ff <= pend_in;
      end
      ih_ff     <= ih_in;
      iw_ff     <= iw_in;
      base_ff   <= base_in;
      row_lo_ff <= row_lo_in;
      col_lo_ff <= col_lo_in;
      col_hi_ff <= col_hi_in;
      max_ff    <= max_in;
   end

   assign max_value   = max_ff;
   assign status.busy = (st_ff != U_IDLE);
   assign status.done = (st_ff == U_DONE);

endmodule

FILE: rtl/int8_max_pool_2d.sv
// Top level of the int8 2-D max pooling block: plane counters, output-window sequencer, line store.
// Each sample beat: accept, the row and column pointer walks (skipping windows that ended
// earlier), row and column checks for each matching row plus a final row check, and per result
// a column check, a scan of (rows x cols) line-store reads (none for all-padding windows) and
// the output beat. The block is not ready for a new sample until the beat is done.
// Reset (synchronous): registers to defaults, counters to zero; line store is not cleared.
module int8_max_pool_2d import mp2d_pkg::*; #(
   parameter int MAX_WIDTH   = MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT  = MAX_HEIGHT_DEF,
   parameter int KERNEL_ROWS = KERNEL_ROWS_DEF,
   parameter int KERNEL_COLS = KERNEL_COLS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   // input stream
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [SAMPLE_W-1:0]  req_tdata,   // [7:0] sample
   // result stream
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [RSP_W-1:0]     rsp_tdata,   // [7:0] pooled, [15:8] result_row, [23:16] result_col
   output logic                 rsp_tlast,   // run_end
   // register writes
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [DIM_W-1:0]     csr_wdata
);

   localparam int ROW_W  = $clog2(MAX_HEIGHT);
   localparam int COL_W  = $clog2(MAX_WIDTH);
   localparam int DEPTH  = KERNEL_ROWS * MAX_WIDTH;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam logic [ADDR_W-1:0] ROW_STEP  = ADDR_W'(MAX_WIDTH);
   localparam logic [ADDR_W-1:0] LAST_BASE = ADDR_W'((KERNEL_ROWS - 1) * MAX_WIDTH);
   localparam pos_type KR_M1 = pos_type'(KERNEL_ROWS - 1);
   localparam pos_type KC_M1 = pos_type'(KERNEL_COLS - 1);

   // registers
   logic [DIM_W-1:0]    in_height_ff, in_width_ff, out_height_ff, out_width_ff;
   logic [STRIDE_W-1:0] stride_rows_ff, stride_cols_ff;
   logic [PAD_W-1:0]    pad_top_ff, pad_left_ff;

   ctrl_state_type             st_ff, st_in;
   logic [ROW_W-1:0]           row_count_ff, row_count_in;
   logic [COL_W-1:0]           col_count_ff, col_count_in;
   logic [ADDR_W-1:0]          row_base_ff, row_base_in;
   logic [DIM_W-1:0]           ph_ptr_ff, ph_ptr_in, pw_ptr_ff, pw_ptr_in;
   pos_type                    rhi_ptr_ff, rhi_ptr_in, chi_ptr_ff, chi_ptr_in;
   logic [DIM_W-1:0]           ph_cur_ff, ph_cur_in, pw_cur_ff, pw_cur_in;
   pos_type                    rhi_cur_ff, rhi_cur_in, chi_cur_ff, chi_cur_in;
   logic [N_W-1:0]             n_ff, n_in;
   logic                       last_ff, last_in;
   logic signed [SAMPLE_W-1:0] pooled_ff, pooled_in;

   // combinational
   logic            req_acc, rsp_acc, finish;
   pos_type         h_last, w_last, r_pos, c_pos, sr, sc;
   logic            row_adv_go, col_adv_go, row_hit, col_hit;
   pos_type         rlo, clo, a0, b0;
   logic            win_empty;
   logic            more_pw, more_ph, first_pw_ok;
   logic            unit_start;
   unit_status_type unit_st;
   logic                       rd_en;
   logic [ADDR_W-1:0]          rd_addr;
   logic [SAMPLE_W-1:0]        rd_data;
   logic signed [SAMPLE_W-1:0] unit_max;

   assign req_acc = req_tvalid && req_tready;
   assign rsp_acc = rsp_tvalid && rsp_tready;

   // effective plane size, last index
   always_comb begin
      if (in_height_ff == '0) begin
         h_last = '0;
      end else if (int'(in_height_ff) > MAX_HEIGHT) begin
         h_last = pos_type'(MAX_HEIGHT - 1);
      end else begin
         h_last = pos_type'(in_height_ff) - pos_type'(1);
      end
      if (in_width_ff == '0) begin
         w_last = '0;
      end else if (int'(in_width_ff) > MAX_WIDTH) begin
         w_last = pos_type'(MAX_WIDTH - 1);
      end else begin
         w_last = pos_type'(in_width_ff) - pos_type'(1);
      end
   end

   assign r_pos = pos_type'(row_count_ff);
   assign c_pos = pos_type'(col_count_ff);
   assign sr    = pos_type'(stride_rows_ff);
   assign sc    = pos_type'(stride_cols_ff);

   // pointers skip windows that ended before the current row / column
   assign row_adv_go = (ph_ptr_ff < out_height_ff) && (r_pos != '0) && (rhi_ptr_ff < r_pos);
   assign col_adv_go = (pw_ptr_ff < out_width_ff) && (c_pos != '0) && (chi_ptr_ff < c_pos);
   assign row_hit    = (ph_cur_ff < out_height_ff) && pos_match(rhi_cur_ff, r_pos, h_last);
   assign col_hit    = (pw_cur_ff < out_width_ff) && pos_match(chi_cur_ff, c_pos, w_last);

   // in-bounds part of the window; its bottom-right corner is the current sample
   assign rlo       = rhi_cur_ff - KR_M1;
   assign clo       = chi_cur_ff - KC_M1;
   assign a0        = (rlo < pos_type'(0)) ? pos_type'(0) : rlo;
   assign b0        = (clo < pos_type'(0)) ? pos_type'(0) : clo;
   assign win_empty = (rhi_cur_ff < pos_type'(0)) || (rlo > r_pos) ||
                      (chi_cur_ff < pos_type'(0)) || (clo > c_pos);

   // look ahead for another result of this beat to place run_end
   assign first_pw_ok = (pw_ptr_ff < out_width_ff) && pos_match(chi_ptr_ff, c_pos, w_last);
   assign more_pw = ({1'b0, pw_cur_ff} + (DIM_W+1)'(1) < {1'b0, out_width_ff}) &&
                    pos_match(chi_cur_ff + sc, c_pos, w_last);
   assign more_ph = ({1'b0, ph_cur_ff} + (DIM_W+1)'(1) < {1'b0, out_height_ff}) &&
                    pos_match(rhi_cur_ff + sr, r_pos, h_last) && first_pw_ok;

   assign finish = ((st_ff == S_ROW_CHK) && !row_hit) ||
                   ((st_ff == S_OUT) && rsp_acc && last_ff);

   // Next state
   always_comb begin
      st_in = st_ff;
      unique case (st_ff)
         S_IDLE: begin
            if (req_acc) st_in = S_ROW_ADV;
         end
         S_ROW_ADV: begin
            if (!row_adv_go) st_in = S_COL_ADV;
         end
         S_COL_ADV: begin
            if (!col_adv_go) st_in = S_ROW_CHK;
         end
         S_ROW_CHK: st_in = row_hit ? S_COL_CHK : S_IDLE;
         S_COL_CHK: begin
            if (!col_hit) st_in = S_ROW_CHK;
            else if (win_empty) st_in = S_OUT;
            else st_in = S_SCAN;
         end
         S_SCAN: begin
            if (unit_st.done) st_in = S_OUT;
         end
         S_OUT: begin
            if (rsp_acc) st_in = last_ff ? S_IDLE : S_COL_CHK;
         end
         default: st_in = S_IDLE;
      endcase
   end

   // Outputs and datapath
   always_comb begin
      row_count_in = row_count_ff;
      col_count_in = col_count_ff;
      row_base_in  = row_base_ff;
      ph_ptr_in    = ph_ptr_ff;
      rhi_ptr_in   = rhi_ptr_ff;
      pw_ptr_in    = pw_ptr_ff;
      chi_ptr_in   = chi_ptr_ff;
      ph_cur_in    = ph_cur_ff;
      rhi_cur_in   = rhi_cur_ff;
      pw_cur_in    = pw_cur_ff;
      chi_cur_in   = chi_cur_ff;
      n_in         = n_ff;
      last_in      = last_ff;
      pooled_in    = pooled_ff;
      unit_start   = 1'b0;
      req_tready   = (st_ff == S_IDLE);
      rsp_tvalid   = (st_ff == S_OUT);

      unique case (st_ff)
         S_IDLE: begin
            if (req_acc) begin
               n_in = '0;
               if (col_count_ff == '0) begin
                  pw_ptr_in  = '0;
                  chi_ptr_in = KC_M1 - pos_type'(pad_left_ff);
                  if (row_count_ff == '0) begin
                     ph_ptr_in  = '0;
                     rhi_ptr_in = KR_M1 - pos_type'(pad_top_ff);
                  end
               end
            end
         end
         S_ROW_ADV: begin
            if (row_adv_go) begin
               ph_ptr_in  = ph_ptr_ff + DIM_W'(1);
               rhi_ptr_in = rhi_ptr_ff + sr;
            end
         end
         S_COL_ADV: begin
            if (col_adv_go) begin
               pw_ptr_in  = pw_ptr_ff + DIM_W'(1);
               chi_ptr_in = chi_ptr_ff + sc;
            end else begin
               ph_cur_in  = ph_ptr_ff;
               rhi_cur_in = rhi_ptr_ff;
            end
         end
         S_ROW_CHK: begin
            if (row_hit) begin
               pw_cur_in  = pw_ptr_ff;
               chi_cur_in = chi_ptr_ff;
            end
         end
         S_COL_CHK: begin
            if (col_hit) begin
               last_in    = (n_ff == N_W'(RES_MAX - 1)) || !(more_pw || more_ph);
               pooled_in  = SAMPLE_MIN;
               unit_start = !win_empty;
            end else begin
               ph_cur_in  = ph_cur_ff + DIM_W'(1);
               rhi_cur_in = rhi_cur_ff + sr;
            end
         end
         S_SCAN: begin
            if (unit_st.done) pooled_in = unit_max;
         end
         S_OUT: begin
            if (rsp_acc) begin
               n_in = n_ff + N_W'(1);
               if (!last_ff) begin
                  pw_cur_in  = pw_cur_ff + DIM_W'(1);
                  chi_cur_in = chi_cur_ff + sc;
               end
            end
         end
         default: begin
         end
      endcase

      // plane position moves on once this sample's results are out
      if (finish) begin
         if (c_pos == w_last) begin
            col_count_in = '0;
            if (r_pos == h_last) begin
               row_count_in = '0;
               row_base_in  = '0;
            end else begin
               row_count_in = row_count_ff + ROW_W'(1);
               row_base_in  = (row_base_ff == LAST_BASE) ? '0 : row_base_ff + ROW_STEP;
            end
         end else begin
            col_count_in = col_count_ff + COL_W'(1);
         end
      end

      // any register write starts a new plane
      if (csr_we) begin
         row_count_in = '0;
         col_count_in = '0;
         row_base_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff          <= S_IDLE;
         row_count_ff   <= '0;
         col_count_ff   <= '0;
         row_base_ff    <= '0;
         n_ff           <= '0;
         in_height_ff   <= IN_HEIGHT_RST;
         in_width_ff    <= IN_WIDTH_RST;
         out_height_ff  <= OUT_HEIGHT_RST;
         out_width_ff   <= OUT_WIDTH_RST;
         stride_rows_ff <= STRIDE_ROWS_RST;
         stride_cols_ff <= STRIDE_COLS_RST;
         pad_top_ff     <= PAD_TOP_RST;
         pad_left_ff    <= PAD_LEFT_RST;
      end else begin
         st_ff        <= st_in;
         row_count_ff <= row_count_in;
         col_count_ff <= col_count_in;
         row_base_ff  <= row_base_in;
         n_ff         <= n_in;
         if (csr_we) begin
            unique case (csr_reg_type'(csr_index))
               REG_IN_HEIGHT:   in_height_ff   <= csr_wdata;
               REG_IN_WIDTH:    in_width_ff    <= csr_wdata;
               REG_OUT_HEIGHT:  out_height_ff  <= csr_wdata;
               REG_OUT_WIDTH:   out_width_ff   <= csr_wdata;
               REG_STRIDE_ROWS: stride_rows_ff <= csr_wdata[STRIDE_W-1:0];
               REG_STRIDE_COLS: stride_cols_ff <= csr_wdata[STRIDE_W-1:0];
               REG_PAD_TOP:     pad_top_ff     <= csr_wdata[PAD_W-1:0];
               REG_PAD_LEFT:    pad_left_ff    <= csr_wdata[PAD_W-1:0];
               default: begin
               end
            endcase
         end
      end
      ph_ptr_ff  <= ph_ptr_in;
      rhi_ptr_ff <= rhi_ptr_in;
      pw_ptr_ff  <= pw_ptr_in;
      chi_ptr_ff <= chi_ptr_in;
      ph_cur_ff  <= ph_cur_in;
      rhi_cur_ff <= rhi_cur_in;
      pw_cur_ff  <= pw_cur_in;
      chi_cur_ff <= chi_cur_in;
      last_ff    <= last_in;
      pooled_ff  <= pooled_in;
   end

   mp2d_ram #(
      .WIDTH (SAMPLE_W),
      .DEPTH (DEPTH)
   ) u_line_store (
      .clock   (clock),
      .wr_en   (req_acc),
      .wr_addr (row_base_ff + ADDR_W'(col_count_ff)),
      .wr_data (req_tdata),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   mp2d_maxunit #(
      .MAX_WIDTH   (MAX_WIDTH),
      .MAX_HEIGHT  (MAX_HEIGHT),
      .KERNEL_ROWS (KERNEL_ROWS)
   ) u_maxunit (
      .clock     (clock),
      .reset     (reset),
      .start     (unit_start),
      .row_lo    (a0[ROW_W-1:0]),
      .row_hi    (row_count_ff),
      .col_lo    (b0[COL_W-1:0]),
      .col_hi    (col_count_ff),
      .base      (row_base_ff),
      .rd_en     (rd_en),
      .rd_addr   (rd_addr),
      .rd_data   (rd_data),
      .max_value (unit_max),
      .status    (unit_st)
   );

   assign rsp_tdata = {pw_cur_ff[IDX_W-1:0], ph_cur_ff[IDX_W-1:0], pooled_ff};
   assign rsp_tlast = last_ff;

   a_res_cap: assert property (@(posedge clock) disable iff (reset)
      n_ff <= N_W'(RES_MAX))
      else $error("more results than the per-beat cap");

   a_one_side: assert property (@(posedge clock) disable iff (reset)
      !(req_tready && rsp_tvalid))
      else $error("input taken while a result is pending");

   a_ready_after_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tready && rsp_tlast) |=> req_tready)
      else $error("not ready after last result of a beat");

   a_scan_owned: assert property (@(posedge clock) disable iff (reset)
      unit_st.busy |-> (st_ff == S_SCAN))
      else $error("window scan running outside scan state");

endmodule

FILE: tb/mp2d_checker.sv
// Checker for int8_max_pool_2d: watches all ports, predicts pooled results and compares them.
module mp2d_checker import mp2d_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   input  logic                 req_tready,
   input  logic [SAMPLE_W-1:0]  req_tdata,   // [7:0] sample
   input  logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   input  logic [RSP_W-1:0]     rsp_tdata,   // [7:0] pooled, [15:8] result_row, [23:16] result_col
   input  logic                 rsp_tlast,   // run_end
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [DIM_W-1:0]     csr_wdata,
   output int                   fail_count,
   output int                   due_count
);

   localparam int KROWS = KERNEL_ROWS_DEF;
   localparam int KCOLS = KERNEL_COLS_DEF;
   localparam int MAXW  = MAX_WIDTH_DEF;
   localparam int MAXH  = MAX_HEIGHT_DEF;

   typedef struct packed {
      logic [SAMPLE_W-1:0] pooled;
      logic [IDX_W-1:0]    out_row;
      logic [IDX_W-1:0]    out_col;
      logic                run_end;
   } pool_beat_type;

   logic [DIM_W-1:0]    in_h, in_w, out_h, out_w;
   logic [STRIDE_W-1:0] step_r, step_c;
   logic [PAD_W-1:0]    pad_t, pad_l;
   int                  row_pos, col_pos;
   logic signed [SAMPLE_W-1:0] line_buf [KROWS*MAXW];
   pool_beat_type       pooled_due[$];

   initial begin
      fail_count = 0;
      due_count  = 0;
   end

   function automatic int clamp_pos(int v, int lo, int hi);
      return (v < lo) ? lo : ((v > hi) ? hi : v);
   endfunction

   // zero size counts as one, oversize is capped
   function automatic int plane_dim(logic [DIM_W-1:0] v, int cap);
      if (v == '0) return 1;
      return (int'(v) > cap) ? cap : int'(v);
   endfunction

   // Store one sample, then queue the windows that it completes, up to RES_MAX, in raster order.
   task automatic pool_sample(input logic signed [SAMPLE_W-1:0] s);
      int            h, w, ph, pw, ih, iw, n;
      int            rlo, rhi, clo, chi, a0, a1, b0, b1, m, sv;
      bit            full, have_prev;
      pool_beat_type prev;
      h = plane_dim(in_h, MAXH);
      w = plane_dim(in_w, MAXW);
      if (row_pos >= h) row_pos = 0;
      if (col_pos >= w) col_pos = 0;
      line_buf[(row_pos % KROWS) * MAXW + col_pos] = s;
      n = 0;
      full = 1'b0;
      have_prev = 1'b0;
      prev = '0;
      for (ph = 0; ph < int'(out_h) && !full; ph++) begin
         rlo = ph * int'(step_r) - int'(pad_t);
         rhi = rlo + KROWS - 1;
         if (clamp_pos(rhi, 0, h - 1) != row_pos) continue;
         for (pw = 0; pw < int'(out_w); pw++) begin
            clo = pw * int'(step_c) - int'(pad_l);
            chi = clo + KCOLS - 1;
            if (clamp_pos(chi, 0, w - 1) != col_pos) continue;
            if (n >= RES_MAX) begin
               full = 1'b1;
               break;
            end
            a0 = (rlo < 0) ? 0 : rlo;
            a1 = (rhi > h - 1) ? h - 1 : rhi;
            b0 = (clo < 0) ? 0 : clo;
            b1 = (chi > w - 1) ? w - 1 : chi;
            m = int'(SAMPLE_MIN);   // padding value, never wins
            for (ih = a0; ih <= a1; ih++) begin
               for (iw = b0; iw <= b1; iw++) begin
                  sv = line_buf[(ih % KROWS) * MAXW + iw];
                  if (sv > m) m = sv;
               end
            end
            if (have_prev) pooled_due.push_back(prev);
            prev.pooled  = m[SAMPLE_W-1:0];
            prev.out_row = ph[IDX_W-1:0];
            prev.out_col = pw[IDX_W-1:0];
            prev.run_end = 1'b0;
            have_prev = 1'b1;
            n++;
         end
      end
      if (have_prev) begin
         prev.run_end = 1'b1;
         pooled_due.push_back(prev);
      end
      col_pos++;
      if (col_pos >= w) begin
         col_pos = 0;
         row_pos++;
         if (row_pos >= h) row_pos = 0;
      end
   endtask

   task automatic check_beat();
      pool_beat_type want;
      if (pooled_due.size() == 0) begin
         $error("result beat with nothing pending: data %h last %b", rsp_tdata, rsp_tlast);
         fail_count++;
         return;
      end
      want = pooled_due.pop_front();
      if (rsp_tdata[7:0] !== want.pooled) begin
         $error("pooled: expected %0d, got %0d", $signed(want.pooled), $signed(rsp_tdata[7:0]));
         fail_count++;
      end
      if (rsp_tdata[15:8] !== want.out_row) begin
         $error("result_row: expected %0d, got %0d", want.out_row, rsp_tdata[15:8]);
         fail_count++;
      end
      if (rsp_tdata[23:16] !== want.out_col) begin
         $error("result_col: expected %0d, got %0d", want.out_col, rsp_tdata[23:16]);
         fail_count++;
      end
      if (rsp_tlast !== want.run_end) begin
         $error("run_end: expected %0d, got %0d", want.run_end, rsp_tlast);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         in_h    = IN_HEIGHT_RST;
         in_w    = IN_WIDTH_RST;
         out_h   = OUT_HEIGHT_RST;
         out_w   = OUT_WIDTH_RST;
         step_r  = STRIDE_ROWS_RST;
         step_c  = STRIDE_COLS_RST;
         pad_t   = PAD_TOP_RST;
         pad_l   = PAD_LEFT_RST;
         row_pos = 0;
         col_pos = 0;
         pooled_due.delete();
      end else begin
         // results of a sample beat never leave in the same cycle, so check first
         if (rsp_tvalid && rsp_tready) check_beat();
         if (csr_we) begin
            case (csr_reg_type'(csr_index))
               REG_IN_HEIGHT:   in_h   = csr_wdata;
               REG_IN_WIDTH:    in_w   = csr_wdata;
               REG_OUT_HEIGHT:  out_h  = csr_wdata;
               REG_OUT_WIDTH:   out_w  = csr_wdata;
               REG_STRIDE_ROWS: step_r = csr_wdata[STRIDE_W-1:0];
               REG_STRIDE_COLS: step_c = csr_wdata[STRIDE_W-1:0];
               REG_PAD_TOP:     pad_t  = csr_wdata[PAD_W-1:0];
               REG_PAD_LEFT:    pad_l  = csr_wdata[PAD_W-1:0];
            endcase
            // any write starts a new plane
            row_pos = 0;
            col_pos = 0;
         end
         if (req_tvalid && req_tready) pool_sample(req_tdata);
      end
      due_count = pooled_due.size();
   end

endmodule

FILE: tb/tb_int8_max_pool_2d.sv
// Testbench top for int8_max_pool_2d: clock, reset, stimulus, watchdog and verdict.
module tb_int8_max_pool_2d;
   import mp2d_pkg::*;

   localparam int SETTLE_CYCLES = 2000;
   localparam int STALL_LIMIT   = 40000;

   typedef struct packed {
      logic [DIM_W-1:0]    in_h;
      logic [DIM_W-1:0]    in_w;
      logic [DIM_W-1:0]    out_h;
      logic [DIM_W-1:0]    out_w;
      logic [STRIDE_W-1:0] step_r;
      logic [STRIDE_W-1:0] step_c;
      logic [PAD_W-1:0]    pad_t;
      logic [PAD_W-1:0]    pad_l;
   } pool_shape_type;

   logic                 clock = 1'b0;
   logic                 reset;
   logic                 req_tvalid;
   logic                 req_tready;
   logic [SAMPLE_W-1:0]  req_tdata;   // [7:0] sample
   logic                 rsp_tvalid;
   logic                 rsp_tready;
   logic [RSP_W-1:0]     rsp_tdata;   // [7:0] pooled, [15:8] result_row, [23:16] result_col
   logic                 rsp_tlast;   // run_end
   logic                 csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [DIM_W-1:0]     csr_wdata;

   int fail_count;
   int due_count;
   int send_idle;
   int recv_idle;
   int quiet_cycles;

   int8_max_pool_2d u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   mp2d_checker u_check (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .fail_count (fail_count),
      .due_count  (due_count)
   );

   always #10 clock = ~clock;

   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(99) >= recv_idle);
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   function automatic pool_shape_type shape_of(int ih, int iw, int oh, int ow,
                                               int sr, int sc, int pt, int pl);
      pool_shape_type sh;
      sh.in_h   = DIM_W'(ih);
      sh.in_w   = DIM_W'(iw);
      sh.out_h  = DIM_W'(oh);
      sh.out_w  = DIM_W'(ow);
      sh.step_r = STRIDE_W'(sr);
      sh.step_c = STRIDE_W'(sc);
      sh.pad_t  = PAD_W'(pt);
      sh.pad_l  = PAD_W'(pl);
      return sh;
   endfunction

   function automatic logic [SAMPLE_W-1:0] extreme_sample(int i);
      case (i % 6)
         0:       return 8'h80;
         1:       return 8'h7F;
         2:       return 8'hFF;
         3:       return 8'h00;
         4:       return 8'h01;
         default: return 8'h81;
      endcase
   endfunction

   task automatic send_sample(input logic [SAMPLE_W-1:0] s);
      @(negedge clock);
      while ($urandom_range(99) < send_idle) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= s;
      do @(posedge clock); while (!req_tready);
   endtask

   // drop valid and hold off until every pending result has come out
   task automatic wait_drained();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (due_count != 0) @(negedge clock);
   endtask

   task automatic write_reg(input csr_reg_type idx, input logic [DIM_W-1:0] val);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
   endtask

   task automatic load_shape(input pool_shape_type sh);
      logic [DIM_W-1:0] junk;
      wait_drained();
      // samples that fire nothing may still be in flight
      repeat (SETTLE_CYCLES) @(negedge clock);
      junk = DIM_W'($urandom_range(0, 511));
      write_reg(REG_IN_HEIGHT,   sh.in_h);
      write_reg(REG_IN_WIDTH,    sh.in_w);
      write_reg(REG_OUT_HEIGHT,  sh.out_h);
      write_reg(REG_OUT_WIDTH,   sh.out_w);
      // upper bits of the narrow registers carry junk that must be ignored
      write_reg(REG_STRIDE_ROWS, {junk[DIM_W-1:STRIDE_W], sh.step_r});
      write_reg(REG_STRIDE_COLS, {junk[STRIDE_W-1:0], junk[DIM_W-1:DIM_W-STRIDE_W-1]});
      write_reg(REG_STRIDE_COLS, {junk[DIM_W-1:STRIDE_W], sh.step_c});
      write_reg(REG_PAD_TOP,     {junk[DIM_W-1:PAD_W], sh.pad_t});
      write_reg(REG_PAD_LEFT,    {junk[DIM_W-1:PAD_W], sh.pad_l});
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   // Mostly whole planes of random samples; now and then a broken plane.
   task automatic random_plane(input bit pause_mid, output int sent);
      pool_shape_type sh;
      int             h, w, n;
      sh.in_h   = DIM_W'($urandom_range(0, 6));
      sh.in_w   = DIM_W'($urandom_range(0, 6));
      sh.out_h  = ($urandom_range(7) == 0) ? DIM_W'($urandom_range(0, 511))
                                           : DIM_W'($urandom_range(0, 4));
      sh.out_w  = ($urandom_range(7) == 0) ? DIM_W'($urandom_range(0, 511))
                                           : DIM_W'($urandom_range(0, 4));
      sh.step_r = ($urandom_range(3) == 0) ? STRIDE_W'($urandom_range(0, 15))
                                           : STRIDE_W'($urandom_range(1, 3));
      sh.step_c = ($urandom_range(3) == 0) ? STRIDE_W'($urandom_range(0, 15))
                                           : STRIDE_W'($urandom_range(1, 3));
      sh.pad_t  = ($urandom_range(3) == 0) ? PAD_W'($urandom_range(0, 7))
                                           : PAD_W'($urandom_range(0, 2));
      sh.pad_l  = ($urandom_range(3) == 0) ? PAD_W'($urandom_range(0, 7))
                                           : PAD_W'($urandom_range(0, 2));
      h = (sh.in_h == 0) ? 1 : int'(sh.in_h);
      w = (sh.in_w == 0) ? 1 : int'(sh.in_w);
      n = h * w * (($urandom_range(3) == 0) ? 2 : 1);
      if ($urandom_range(4) == 0) n = $urandom_range(1, h * w + 3);
      load_shape(sh);
      for (int i = 0; i < n; i++) begin
         if (pause_mid && i == n / 2) wait_drained();
         send_sample(SAMPLE_W'($urandom_range(0, 255)));
      end
      sent = n;
   endtask

   initial begin
      int sent;
      int random_items;
      int planes;
      reset        = 1'b1;
      req_tvalid   = 1'b0;
      req_tdata    = '0;
      rsp_tready   = 1'b0;
      csr_we       = 1'b0;
      csr_index    = REG_IN_HEIGHT;
      csr_wdata    = '0;
      send_idle    = 28;
      recv_idle    = 28;
      quiet_cycles = 0;
      random_items = 0;
      planes       = 0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset shape: 8x8 plane, 3x3 windows at stride 2; first window closes on sample 18
      for (int i = 0; i < 19; i++) send_sample(extreme_sample(i));

      // zero sizes, zero strides, window wholly in padding: 1x1 plane, two planes
      load_shape(shape_of(0, 0, 1, 1, 0, 0, 3, 3));
      send_sample(8'h7F);
      send_sample(8'h80);

      // 81 windows on one sample: only the first 64 come out
      load_shape(shape_of(1, 1, 9, 9, 0, 0, 0, 0));
      send_sample(8'h80);

      // oversized plane: sizes are capped, first window fires on the first sample
      load_shape(shape_of(511, 511, 1, 1, 0, 0, 2, 2));
      for (int i = 0; i < 4; i++) send_sample(SAMPLE_W'($urandom_range(0, 255)));

      while (random_items < 74) begin
         send_idle = (planes == 2) ? 0 : 28;
         recv_idle = send_idle;
         random_plane(planes == 0, sent);
         random_items += sent;
         planes++;
      end

      wait_drained();
      repeat (SETTLE_CYCLES) @(negedge clock);
      if (fail_count == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule
